### design/wnpc_pkg.sv
// ----------------------------------------------------------------------------
// wnpc_pkg
// Shared types and constants for the weighted nearest palette color block.
// ----------------------------------------------------------------------------
package wnpc_pkg;

    localparam int COLOR_W = 8;
    localparam int INDEX_W = 8;
    localparam int SQ_W    = 2 * COLOR_W;
    localparam int PROD_W  = SQ_W + COLOR_W;
    localparam int DIST_W  = PROD_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_START = {DIST_W{1'b1}};

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT  = 2'd2;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic               command;
        logic [INDEX_W-1:0] entry_index;
        rgb_t               color;
        logic [DIST_W-1:0]  best_dist;
        logic [INDEX_W-1:0] best_idx;
    } link_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } weights_t;

endpackage

### design/wnpc_cell.sv
// ----------------------------------------------------------------------------
// wnpc_cell
// One palette entry with a three-stage weighted distance compare; items pass
// to the next cell as they leave the last stage.
// ----------------------------------------------------------------------------
module wnpc_cell
    import wnpc_pkg::*;
#(
    parameter logic [7:0] CELL_INDEX = 8'd0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  weights_t weights,
    input  logic     in_valid,
    input  link_t    in_link,
    output logic     out_valid,
    output link_t    out_link
);

    rgb_t               entry_reg;
    logic [2:0]         valid_reg;
    link_t              s1_link_reg;
    link_t              s2_link_reg;
    link_t              s3_link_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [PROD_W-1:0]  prod_r_reg, prod_g_reg, prod_b_reg;

    logic [COLOR_W-1:0] dr, dg, db;
    logic [DIST_W-1:0]  wdist;
    logic               hit;
    link_t              s3_link_next;

    assign hit = in_valid && (in_link.command == CMD_LOAD) &&
                 (in_link.entry_index == CELL_INDEX);

    assign dr = (entry_reg.red > in_link.color.red) ?
                entry_reg.red - in_link.color.red : in_link.color.red - entry_reg.red;
    assign dg = (entry_reg.green > in_link.color.green) ?
                entry_reg.green - in_link.color.green :
                in_link.color.green - entry_reg.green;
    assign db = (entry_reg.blue > in_link.color.blue) ?
                entry_reg.blue - in_link.color.blue : in_link.color.blue - entry_reg.blue;

    assign wdist = DIST_W'(prod_r_reg) + DIST_W'(prod_g_reg) + DIST_W'(prod_b_reg);

    always_comb
    begin
        s3_link_next = s2_link_reg;
        if (wdist < s2_link_reg.best_dist)
        begin
            s3_link_next.best_dist = wdist;
            s3_link_next.best_idx  = CELL_INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            valid_reg <= '0;
        end
        else if (adv)
        begin
            if (hit)
            begin
                entry_reg <= in_link.color;
            end
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_link_reg <= in_link;
            sq_r_reg    <= SQ_W'(dr) * SQ_W'(dr);
            sq_g_reg    <= SQ_W'(dg) * SQ_W'(dg);
            sq_b_reg    <= SQ_W'(db) * SQ_W'(db);
            s2_link_reg <= s1_link_reg;
            prod_r_reg  <= PROD_W'(weights.red) * PROD_W'(sq_r_reg);
            prod_g_reg  <= PROD_W'(weights.green) * PROD_W'(sq_g_reg);
            prod_b_reg  <= PROD_W'(weights.blue) * PROD_W'(sq_b_reg);
            s3_link_reg <= s3_link_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_link  = s3_link_reg;

endmodule

### design/wnpc_obuf.sv
// ----------------------------------------------------------------------------
// wnpc_obuf
// Two-entry result buffer between the cell chain and the output channel.
// ----------------------------------------------------------------------------
module wnpc_obuf
    import wnpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [INDEX_W-1:0] push_data,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] out_data
);

    logic [1:0]         count_reg, count_next;
    logic [INDEX_W-1:0] slot0_reg, slot1_reg;
    logic               pop;

    assign pop       = (count_reg != 2'd0) && !out_stall;
    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
        if (push)
        begin
            case ({pop, count_reg})
                3'b000:  slot0_reg <= push_data;
                3'b001:  slot1_reg <= push_data;
                3'b101:  slot0_reg <= push_data;
                3'b110:  slot1_reg <= push_data;
                default: slot1_reg <= push_data;
            endcase
        end
    end

endmodule

### design/weighted_nearest_palette_color.sv
// ----------------------------------------------------------------------------
// weighted_nearest_palette_color
// Nearest palette entry under a weighted squared RGB distance.
// ----------------------------------------------------------------------------
// Input items transfer when in_valid is high and in_stall is low. A load
// (command 0) writes palette entry entry_index and gives no result; a load
// beyond the palette is dropped. A query (command 1) gives one result,
// best_index, which transfers when out_valid is high and out_stall is low.
// Ties go to the lowest index.
// Every item walks a chain of PALETTE_ENTRIES cells, one cell per entry,
// each three register stages deep, so one item can be taken every cycle
// while in_stall is low. A query's result passes through the result buffer
// after the last cell. Loads and queries stay in order.
// A two-entry result buffer sits at the output; the chain freezes and
// in_stall rises only when that buffer is full and a query is leaving the
// last cell.
// Weights are written on the cfg channel (cfg_ready is always high); the user
// must change them only while the block is idle, which it does not enforce.
// Reset zeroes the palette, sets each weight to 1, empties chain and buffer.
// ----------------------------------------------------------------------------
module weighted_nearest_palette_color
    import wnpc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [INDEX_W-1:0]   entry_index,
    input  logic [COLOR_W-1:0]   red,
    input  logic [COLOR_W-1:0]   green,
    input  logic [COLOR_W-1:0]   blue,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [INDEX_W-1:0]   best_index,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    weights_t               weights_reg;
    logic [PALETTE_ENTRIES:0] chain_valid;
    link_t                  chain_link [PALETTE_ENTRIES+1];
    logic                   adv;
    logic                   room;
    logic                   last_query;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.red   <= COLOR_W'(1);
            weights_reg.green <= COLOR_W'(1);
            weights_reg.blue  <= COLOR_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RED_WEIGHT:   weights_reg.red   <= cfg_data;
                REG_GREEN_WEIGHT: weights_reg.green <= cfg_data;
                REG_BLUE_WEIGHT:  weights_reg.blue  <= cfg_data;
                default:          weights_reg       <= weights_reg;
            endcase
        end
    end

    assign last_query = chain_valid[PALETTE_ENTRIES] &&
                        (chain_link[PALETTE_ENTRIES].command == CMD_QUERY);
    assign adv        = !last_query || room;
    assign in_stall   = !adv;

    assign chain_valid[0]                = in_valid;
    assign chain_link[0].command         = command;
    assign chain_link[0].entry_index     = entry_index;
    assign chain_link[0].color.red       = red;
    assign chain_link[0].color.green     = green;
    assign chain_link[0].color.blue      = blue;
    assign chain_link[0].best_dist       = DIST_START;
    assign chain_link[0].best_idx        = '0;

    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_cell
        wnpc_cell #(
            .CELL_INDEX (8'(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .weights   (weights_reg),
            .in_valid  (chain_valid[i]),
            .in_link   (chain_link[i]),
            .out_valid (chain_valid[i+1]),
            .out_link  (chain_link[i+1])
        );
    end

    wnpc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (last_query && adv),
        .push_data (chain_link[PALETTE_ENTRIES].best_idx),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (best_index)
    );

endmodule

### test/weighted_nearest_palette_color_tb.sv
// ----------------------------------------------------------------------------
// weighted_nearest_palette_color_tb
// Loads palette entries and sends color queries through the input channel.
// Each returned best_index is checked against a software copy of the palette
// and the channel weights. Weights change between phases, with the block idle.
// ----------------------------------------------------------------------------
module weighted_nearest_palette_color_tb;
    import wnpc_pkg::*;

    localparam int ENTRIES    = 256;
    localparam int LATENCY    = 3 * ENTRIES + 1;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_ITEMS = 240;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    class palette_match_scoreboard;
        rgb_t               palette [ENTRIES];
        logic [COLOR_W-1:0] w_red;
        logic [COLOR_W-1:0] w_green;
        logic [COLOR_W-1:0] w_blue;
        logic [INDEX_W-1:0] expected_best [$];
        int                 error_count;

        function new();
            foreach (palette[i])
                palette[i] = '0;
            w_red = 8'd1;
            w_green = 8'd1;
            w_blue = 8'd1;
            error_count = 0;
        endfunction

        function void write_weight(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
            case (idx)
                REG_RED_WEIGHT:   w_red = data;
                REG_GREEN_WEIGHT: w_green = data;
                REG_BLUE_WEIGHT:  w_blue = data;
                default: ;
            endcase
        endfunction

        function logic [INDEX_W-1:0] nearest_entry(rgb_t q);
            int dr;
            int dg;
            int db;
            int wdist;
            int best_dist;
            logic [INDEX_W-1:0] best;
            best_dist = 32'h7FFF_FFFF;
            best = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                dr = int'(palette[i].red) - int'(q.red);
                dg = int'(palette[i].green) - int'(q.green);
                db = int'(palette[i].blue) - int'(q.blue);
                wdist = int'(w_red) * dr * dr + int'(w_green) * dg * dg
                      + int'(w_blue) * db * db;
                if (wdist < best_dist) begin
                    best_dist = wdist;
                    best = i[INDEX_W-1:0];
                end
            end
            return best;
        endfunction

        function void note_item(logic cmd, logic [INDEX_W-1:0] idx, rgb_t color);
            if (cmd == CMD_LOAD) begin
                if (idx < ENTRIES)
                    palette[idx] = color;
            end else begin
                expected_best.push_back(nearest_entry(color));
            end
        endfunction

        function void check_best(logic [INDEX_W-1:0] actual);
            logic [INDEX_W-1:0] want;
            if (expected_best.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result transfer: best_index=%0d", actual);
                error_count++;
            end else begin
                want = expected_best.pop_front();
                if (actual !== want) begin
                    if (error_count < 10)
                        $display("best_index mismatch: expected %0d, got %0d", want, actual);
                    error_count++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_best.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 command = CMD_LOAD;
    logic [INDEX_W-1:0]   entry_index = '0;
    logic [COLOR_W-1:0]   red = '0;
    logic [COLOR_W-1:0]   green = '0;
    logic [COLOR_W-1:0]   blue = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [INDEX_W-1:0]   best_index;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]   cfg_data = '0;

    palette_match_scoreboard board = new();
    bit          idle_on = 1'b1;
    logic        stall_on = 1'b1;
    int unsigned quiet_cycles = 0;

    weighted_nearest_palette_color #(
        .PALETTE_ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .entry_index(entry_index),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .best_index(best_index),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_best(best_index);
            out_stall <= stall_on && ($urandom_range(99) < 26);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)
                && !(cfg_valid && cfg_ready))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("weighted_nearest_palette_color_tb: done, errors");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx, input rgb_t color);
        while (idle_on && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        red         <= color.red;
        green       <= color.green;
        blue        <= color.blue;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(cmd, idx, color);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_weight(idx, data);
    endtask

    task automatic set_weights(input logic [COLOR_W-1:0] wr, input logic [COLOR_W-1:0] wg,
                               input logic [COLOR_W-1:0] wb);
        write_register(REG_RED_WEIGHT, wr);
        write_register(REG_GREEN_WEIGHT, wg);
        write_register(REG_BLUE_WEIGHT, wb);
        write_register(REG_UNUSED, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
    endtask

    // stop sending until all queries have returned; optionally let trailing loads clear
    task automatic quiesce(input bit settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        if (settle)
            repeat (LATENCY + 16) @(posedge clk);
    endtask

    task automatic send_random();
        logic               cmd;
        logic [INDEX_W-1:0] idx;
        rgb_t               c;
        rgb_t               seen;
        int                 pick;
        int                 v;
        cmd  = 1'($urandom_range(1));
        idx  = 8'($urandom_range(255));
        pick = int'($urandom_range(99));
        seen = board.palette[8'($urandom_range(ENTRIES - 1))];
        for (int i = 0; i < 3; i++)
            c[8*i +: 8] = 8'($urandom_range(255));
        if (cmd == CMD_LOAD)
        begin
            if (pick < 15)
                c = seen;
            else if (pick < 30)
                for (int i = 0; i < 3; i++)
                    c[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else
        begin
            if (pick < 20)
                c = seen;
            else if (pick < 60)
                for (int i = 0; i < 3; i++)
                begin
                    v = int'(seen[8*i +: 8]) + int'($urandom_range(8)) - 4;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    c[8*i +: 8] = 8'(v);
                end
        end
        send_item(cmd, idx, c);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty palette, then extremes, ties and single-entry hits
        send_item(CMD_QUERY, 8'd255, '{8'd0, 8'd0, 8'd0});
        send_item(CMD_QUERY, 8'd0, '{8'd255, 8'd255, 8'd255});
        send_item(CMD_LOAD, 8'd255, '{8'd255, 8'd255, 8'd255});
        send_item(CMD_QUERY, 8'd17, '{8'd255, 8'd255, 8'd255});
        send_item(CMD_LOAD, 8'd0, '{8'd255, 8'd255, 8'd255});
        send_item(CMD_QUERY, 8'd255, '{8'd255, 8'd255, 8'd255});
        send_item(CMD_LOAD, 8'd128, '{8'h80, 8'h7F, 8'h01});
        send_item(CMD_QUERY, 8'd128, '{8'h80, 8'h7F, 8'h01});
        send_item(CMD_LOAD, 8'd1, '{8'd0, 8'd255, 8'd0});
        send_item(CMD_QUERY, 8'd1, '{8'd0, 8'd200, 8'd0});
        send_item(CMD_LOAD, 8'd2, '{8'd0, 8'd0, 8'd255});
        send_item(CMD_QUERY, 8'd2, '{8'd0, 8'd0, 8'd250});
        send_item(CMD_LOAD, 8'd3, '{8'd255, 8'd0, 8'd0});
        send_item(CMD_QUERY, 8'd3, '{8'd250, 8'd10, 8'd10});
        send_item(CMD_LOAD, 8'd170, '{8'hAA, 8'h55, 8'hAA});
        send_item(CMD_QUERY, 8'd85, '{8'h55, 8'hAA, 8'h55});
        quiesce(1'b1);

        // all weights zero: every distance ties, entry 0 wins
        set_weights(8'd0, 8'd0, 8'd0);
        send_item(CMD_LOAD, 8'd7, '{8'd1, 8'd2, 8'd3});
        send_item(CMD_QUERY, 8'd7, '{8'd1, 8'd2, 8'd3});
        send_item(CMD_QUERY, 8'd0, '{8'd255, 8'd0, 8'd255});
        quiesce(1'b1);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_weights(8'd255, 8'd255, 8'd255);
                1: set_weights(8'd0, 8'd1, 8'd255);
                4: set_weights(8'd3, 8'd6, 8'd1);
                default: set_weights(8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
            endcase
            idle_on = (p != 2);
            stall_on <= (p != 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 3 && k == PHASE_ITEMS / 2)
                    quiesce(1'b0);
                send_random();
            end
            quiesce(1'b1);
        end

        if (board.pending() != 0)
            board.error_count++;
        if (board.error_count == 0)
            $display("weighted_nearest_palette_color_tb: done, clean");
        else
            $display("weighted_nearest_palette_color_tb: done, errors");
        $finish;
    end

endmodule
